/* rtl/rdc_pkg.sv */
package rdc_pkg;

  // Field widths of the item channels
  localparam int unsigned NUM_W      = 60;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned DIG_W      = 4;

  // Default length of a result in decimal digits
  localparam int unsigned DIGITS_DEF = 18;

  // A 60-bit number has up to 19 decimal digits
  localparam int unsigned IN_DIGITS  = 19;
  localparam int unsigned BCD_W      = IN_DIGITS * DIG_W;

  // Binary to BCD conversion: input bits taken per cycle and number of steps
  localparam int unsigned DAB_BITS   = 4;
  localparam int unsigned DAB_STEPS  = NUM_W / DAB_BITS;

  // Conversion modes, source to target
  typedef enum logic [CMD_W-1:0] {
    CMD_BIN_DEC = 3'd0,
    CMD_DEC_BIN = 3'd1,
    CMD_BIN_OCT = 3'd2,
    CMD_OCT_BIN = 3'd3,
    CMD_OCT_DEC = 3'd4,
    CMD_DEC_OCT = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    BASE_2  = 2'd0,
    BASE_8  = 2'd1,
    BASE_10 = 2'd2
  } base_e;

  // Controls of the BCD conversion unit
  typedef struct packed {
    logic load;   // take a new binary number, clear the digits
    logic conv;   // run one conversion step
    logic shift;  // drop the top digit, move the next one up
  } bcd_ctrl_t;

  function automatic logic cmd_ok(logic [CMD_W-1:0] cmd);
    logic ok;
    case (cmd)
      CMD_BIN_DEC, CMD_DEC_BIN, CMD_BIN_OCT,
      CMD_OCT_BIN, CMD_OCT_DEC, CMD_DEC_OCT: ok = 1'b1;
      default:                               ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic base_e src_base(logic [CMD_W-1:0] cmd);
    base_e b;
    case (cmd)
      CMD_BIN_DEC, CMD_BIN_OCT: b = BASE_2;
      CMD_OCT_BIN, CMD_OCT_DEC: b = BASE_8;
      default:                  b = BASE_10;
    endcase
    return b;
  endfunction

  function automatic base_e dst_base(logic [CMD_W-1:0] cmd);
    base_e b;
    case (cmd)
      CMD_DEC_BIN, CMD_OCT_BIN: b = BASE_2;
      CMD_BIN_OCT, CMD_DEC_OCT: b = BASE_8;
      default:                  b = BASE_10;
    endcase
    return b;
  endfunction

  // Power of ten, for elaboration-time constants
  function automatic logic [63:0] pow10(int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned k = 0; k < n; k++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

/* rtl/rdc_in_if.sv */
interface rdc_in_if;
  import rdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [NUM_W-1:0]   number_in;

  modport source (output valid, output cmd, output number_in, input ready);
  modport sink   (input valid, input cmd, input number_in, output ready);
endinterface

/* rtl/rdc_out_if.sv */
interface rdc_out_if;
  import rdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [NUM_W-1:0]   number_out;
  logic               overflow;

  modport source (output valid, output number_out, output overflow, input ready);
  modport sink   (input valid, input number_out, input overflow, output ready);
endinterface

/* rtl/rdc_mac.sv */
module rdc_mac (
  input  logic [rdc_pkg::NUM_W-1:0] acc_i,
  input  rdc_pkg::base_e            base_i,
  input  logic [rdc_pkg::DIG_W-1:0] digit_i,
  output logic [rdc_pkg::NUM_W-1:0] sum_o
);
  import rdc_pkg::*;

  logic [NUM_W-1:0] scaled;

  // Scale the accumulator by the base with shifts, then add the digit
  always_comb begin
    case (base_i)
      BASE_2:  scaled = acc_i << 1;
      BASE_8:  scaled = acc_i << 3;
      BASE_10: scaled = (acc_i << 3) + (acc_i << 1);
      default: scaled = acc_i;
    endcase
  end

  assign sum_o = scaled + NUM_W'(digit_i);

endmodule

/* rtl/rdc_bcd.sv */
module rdc_bcd (
  input  logic                      clk_i,
  input  rdc_pkg::bcd_ctrl_t        ctrl_i,
  input  logic [rdc_pkg::NUM_W-1:0] bin_i,
  output logic [rdc_pkg::DIG_W-1:0] digit_o
);
  import rdc_pkg::*;

  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [NUM_W-1:0] bin_q, bin_d;

  // Shift-and-add-3: several input bits per cycle, each digit corrected
  // before every single-bit shift
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [NUM_W-1:0] s;
    b = bcd_q;
    s = bin_q;
    for (int unsigned k = 0; k < DAB_BITS; k++) begin
      for (int unsigned d = 0; d < IN_DIGITS; d++) begin
        if (b[d*DIG_W +: DIG_W] >= DIG_W'(5)) begin
          b[d*DIG_W +: DIG_W] = b[d*DIG_W +: DIG_W] + DIG_W'(3);
        end
      end
      b = {b[BCD_W-2:0], s[NUM_W-1]};
      s = {s[NUM_W-2:0], 1'b0};
    end
    bcd_d = bcd_q;
    bin_d = bin_q;
    if (ctrl_i.load) begin
      bcd_d = '0;
      bin_d = bin_i;
    end else if (ctrl_i.conv) begin
      bcd_d = b;
      bin_d = s;
    end else if (ctrl_i.shift) begin
      bcd_d = {bcd_q[BCD_W-DIG_W-1:0], DIG_W'(0)};
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
  end

  // Most significant decimal digit
  assign digit_o = bcd_q[BCD_W-1 -: DIG_W];

endmodule

/* rtl/radix_digit_converter.sv */
// Number base converter. Each item carries a mode (binary, octal or decimal
// source and target) and a number whose decimal digits are read as digits
// of the source base, each at its face value even when it exceeds the base.
// The value is returned with its target-base digits written as a decimal
// pattern; a result longer than DIGITS digits gives DIGITS nines and sets
// overflow. One item is in work at a time and the input is not ready until
// its result has been taken. A decimal source goes straight to the range
// check and, for a binary or octal target, on to the digit write-out. A
// binary or octal source first goes through a binary-to-BCD converter
// (four bits a cycle) and a digit-serial read of all 19 digits through
// the shared multiply-add unit before the range check; the write-out runs
// one digit a cycle through the same unit. Unused modes return zero.
module radix_digit_converter #(
  parameter int unsigned DIGITS = rdc_pkg::DIGITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rdc_in_if.sink    in_i,
  rdc_out_if.source out_o
);
  import rdc_pkg::*;

  localparam int unsigned CNT_W   = $clog2(IN_DIGITS);
  localparam int unsigned BIN_TOP = DIGITS - 1;
  localparam int unsigned OCT_TOP = 3 * DIGITS - 1;
  localparam logic [NUM_W-1:0] LIM2  = NUM_W'(1) << DIGITS;
  localparam logic [NUM_W-1:0] LIM8  = NUM_W'(1) << (3 * DIGITS);
  localparam logic [NUM_W-1:0] LIM10 = NUM_W'(pow10(DIGITS));
  localparam logic [NUM_W-1:0] NINES = LIM10 - NUM_W'(1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CONV  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  base_e            sb_q, sb_d, tb_q, tb_d;
  logic [NUM_W-1:0] acc_q, acc_d;
  logic [NUM_W-1:0] sh_q, sh_d;
  logic [NUM_W-1:0] out_num_q, out_num_d;
  logic             out_ovf_q, out_ovf_d;

  bcd_ctrl_t        bcd_ctrl;
  logic [DIG_W-1:0] bcd_digit;
  base_e            mac_base;
  logic [DIG_W-1:0] mac_digit;
  logic [NUM_W-1:0] mac_sum;
  logic [NUM_W-1:0] limit;
  logic             accept;

  assign accept = in_i.valid && in_i.ready;

  rdc_bcd u_bcd (
    .clk_i   (clk_i),
    .ctrl_i  (bcd_ctrl),
    .bin_i   (in_i.number_in),
    .digit_o (bcd_digit)
  );

  // Shared unit: source-base read, then times-ten write-out
  always_comb begin
    if (state_q == ST_READ) begin
      mac_base  = sb_q;
      mac_digit = bcd_digit;
    end else begin
      mac_base  = BASE_10;
      mac_digit = (tb_q == BASE_2) ? DIG_W'(sh_q[BIN_TOP]) : DIG_W'(sh_q[OCT_TOP -: 3]);
    end
  end

  rdc_mac u_mac (
    .acc_i   (acc_q),
    .base_i  (mac_base),
    .digit_i (mac_digit),
    .sum_o   (mac_sum)
  );

  // Largest value that fits in DIGITS target digits, plus one
  always_comb begin
    case (tb_q)
      BASE_2:  limit = LIM2;
      BASE_8:  limit = LIM8;
      default: limit = LIM10;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    sb_d      = sb_q;
    tb_d      = tb_q;
    acc_d     = acc_q;
    sh_d      = sh_q;
    out_num_d = out_num_q;
    out_ovf_d = out_ovf_q;
    bcd_ctrl  = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sb_d = src_base(in_i.cmd);
          tb_d = dst_base(in_i.cmd);
          cnt_d = '0;
          if (!cmd_ok(in_i.cmd)) begin
            out_num_d = '0;
            out_ovf_d = 1'b0;
            state_d   = ST_DONE;
          end else if (src_base(in_i.cmd) == BASE_10) begin
            acc_d   = in_i.number_in;
            state_d = ST_EVAL;
          end else begin
            bcd_ctrl.load = 1'b1;
            state_d       = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        bcd_ctrl.conv = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DAB_STEPS - 1)) begin
          cnt_d   = '0;
          acc_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        bcd_ctrl.shift = 1'b1;
        acc_d = mac_sum;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(IN_DIGITS - 1)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (acc_q >= limit) begin
          out_num_d = NINES;
          out_ovf_d = 1'b1;
          state_d   = ST_DONE;
        end else if (tb_q == BASE_10) begin
          out_num_d = acc_q;
          out_ovf_d = 1'b0;
          state_d   = ST_DONE;
        end else begin
          sh_d    = acc_q;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        acc_d = mac_sum;
        sh_d  = (tb_q == BASE_2) ? (sh_q << 1) : (sh_q << 3);
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIGITS - 1)) begin
          out_num_d = mac_sum;
          out_ovf_d = 1'b0;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    sb_q      <= sb_d;
    tb_q      <= tb_d;
    acc_q     <= acc_d;
    sh_q      <= sh_d;
    out_num_q <= out_num_d;
    out_ovf_q <= out_ovf_d;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = (state_q == ST_DONE);
  assign out_o.number_out = out_num_q;
  assign out_o.overflow   = out_ovf_q;

endmodule
